[rtl/spq_pkg.sv]
// Package for the sorted priority queue: sizes, operation and status codes,
// and the structs passed along the row of cells.
// Has no dependencies; every other file uses it by scoped names.
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 16;
    localparam int TAG_W = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_HEAD   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic             ins_en;
        logic             rem_en;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_cmd;

    typedef struct packed {
        t_entry           entry;
        logic             ins_flag;
        logic             seen;
        logic [KEY_W-1:0] sel_key;
        logic [TAG_W-1:0] sel_tag;
    } t_link;

endpackage

[rtl/spq_cell.sv]
// One storage cell of the sorted priority queue: holds one entry, shifts on
// insert and remove, and forwards the insert and tag-match chains.
// Depends on spq_pkg.
module spq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spq_pkg::t_cmd   i_cmd,
    input  spq_pkg::t_link  i_left,
    input  spq_pkg::t_entry i_right,
    output spq_pkg::t_link  o_link
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            w_ins_flag;
    logic            w_match;
    logic            w_through;
    logic            w_hit;

    always_comb begin
        w_ins_flag = !r_entry.valid || (i_cmd.key > r_entry.key);
        w_match    = r_entry.valid && (r_entry.tag == i_cmd.tag);
        w_through  = i_left.seen || w_match;
        w_hit      = w_match && !i_left.seen;

        n_entry = r_entry;
        if (i_cmd.ins_en && w_ins_flag) begin
            if (i_left.ins_flag) begin
                n_entry = i_left.entry;
            end else begin
                n_entry.valid = 1'b1;
                n_entry.key   = i_cmd.key;
                n_entry.tag   = i_cmd.tag;
            end
        end else if (i_cmd.rem_en && w_through) begin
            n_entry = i_right;
        end

        o_link.entry    = r_entry;
        o_link.ins_flag = w_ins_flag;
        o_link.seen     = w_through;
        o_link.sel_key  = i_left.sel_key | (w_hit ? r_entry.key : '0);
        o_link.sel_tag  = i_left.sel_tag | (w_hit ? r_entry.tag : '0);
    end

    always_ff @(posedge i_clk) begin
        r_entry.key <= n_entry.key;
        r_entry.tag <= n_entry.tag;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

endmodule

[rtl/sorted_priority_queue_top.sv]
// Top level of the sorted priority queue: stream ports, the row of cells,
// the entry count and the result register.
// Depends on spq_pkg and spq_cell.
//
//   Channel   Direction  Contents
//   s_axis    in         operation: tuser opcode, tdata key and tag
//   m_axis    out        result: tuser status, tdata key, tag and count
//
// All cells compare in parallel and the
// result is registered at the edge that accepts the transaction.
// A new transaction is taken whenever the result register is empty or its
// result is being taken in the same cycle; a stalled output holds the input.
// Reset empties the queue at once; no clearing pass is needed.
module sorted_priority_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] priority_key, [31:16] entry_tag
    input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [15:0] result_key, [31:16] result_tag,
                                       // [36:32] entry_count
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    localparam int DEPTH = spq_pkg::DEPTH;
    localparam int KEY_W = spq_pkg::KEY_W;
    localparam int TAG_W = spq_pkg::TAG_W;
    localparam int CNT_W = spq_pkg::CNT_W;

    spq_pkg::t_cmd  w_cmd;
    spq_pkg::t_link w_link [DEPTH];
    spq_pkg::t_link w_left [DEPTH];
    spq_pkg::t_entry w_right [DEPTH];

    logic             w_fire;
    logic [1:0]       w_op;
    logic             w_full;
    logic             w_found;
    logic [1:0]       w_status;
    logic [KEY_W-1:0] w_res_key;
    logic [TAG_W-1:0] w_res_tag;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [KEY_W-1:0] r_key;
    logic [TAG_W-1:0] r_tag;
    logic [CNT_W-1:0] r_out_count;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_fire        = s_axis_tvalid && s_axis_tready;
    assign w_op          = s_axis_tuser;
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_found       = w_link[DEPTH-1].seen;

    always_comb begin
        w_cmd.key    = s_axis_tdata[KEY_W-1:0];
        w_cmd.tag    = s_axis_tdata[KEY_W +: TAG_W];
        w_cmd.ins_en = w_fire && (w_op == spq_pkg::OP_INSERT) && !w_full;
        w_cmd.rem_en = w_fire && (w_op == spq_pkg::OP_REMOVE) && w_found;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign w_left[gi] = '0;
            end else begin : g_mid
                assign w_left[gi] = w_link[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right[gi] = '0;
            end else begin : g_inner
                assign w_right[gi] = w_link[gi+1].entry;
            end
            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_left  (w_left[gi]),
                .i_right (w_right[gi]),
                .o_link  (w_link[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count   = r_count;
        w_status  = spq_pkg::ST_OK;
        w_res_key = '0;
        w_res_tag = '0;
        case (w_op)
            spq_pkg::OP_INSERT: begin
                if (w_full) begin
                    w_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            spq_pkg::OP_REMOVE: begin
                if (w_found) begin
                    n_count   = r_count - CNT_W'(1);
                    w_res_key = w_link[DEPTH-1].sel_key;
                    w_res_tag = w_link[DEPTH-1].sel_tag;
                end else begin
                    w_status = spq_pkg::ST_NOT_FOUND;
                end
            end
            spq_pkg::OP_FIND: begin
                if (w_found) begin
                    w_res_key = w_link[DEPTH-1].sel_key;
                    w_res_tag = w_link[DEPTH-1].sel_tag;
                end else begin
                    w_status = spq_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                if (r_count == '0) begin
                    w_status = spq_pkg::ST_EMPTY;
                end else begin
                    w_res_key = w_link[0].entry.key;
                    w_res_tag = w_link[0].entry.tag;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status    <= w_status;
            r_key       <= w_res_key;
            r_tag       <= w_res_tag;
            r_out_count <= n_count;
        end
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count <= n_count;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {(40 - KEY_W - TAG_W - CNT_W)'(0), r_out_count, r_tag, r_key};

endmodule

[sim/spq_checker.sv]
// Checker for the sorted priority queue: watches both stream channels, predicts
// each result from its own copy of the queue and compares field by field.
// Depends on spq_pkg for sizes and operation and status codes.
module spq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,  // [15:0] priority_key, [31:16] entry_tag
    input  logic [1:0]  i_s_tuser,  // [1:0] opcode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,  // [15:0] result_key, [31:16] result_tag,
                                    // [36:32] entry_count
    input  logic [1:0]  i_m_tuser,  // [1:0] status
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [1:0]                 status;
        logic [spq_pkg::KEY_W-1:0]  key;
        logic [spq_pkg::TAG_W-1:0]  tag;
        logic [spq_pkg::CNT_W-1:0]  count;
    } t_spq_result;

    logic [spq_pkg::KEY_W-1:0] queue_keys [spq_pkg::DEPTH];
    logic [spq_pkg::TAG_W-1:0] queue_tags [spq_pkg::DEPTH];
    int                        queue_len;
    t_spq_result               expected_results [$];
    int                        err_cnt;
    int                        chk_cnt;

    function automatic int tag_position(input logic [spq_pkg::TAG_W-1:0] tag);
        for (int i = 0; i < queue_len; i++) begin
            if (queue_tags[i] == tag) begin
                return i;
            end
        end
        return spq_pkg::DEPTH;
    endfunction

    function automatic t_spq_result queue_operation(input logic [1:0] op,
                                                    input logic [spq_pkg::KEY_W-1:0] key,
                                                    input logic [spq_pkg::TAG_W-1:0] tag);
        t_spq_result res;
        int          pos;
        res        = '0;
        res.status = spq_pkg::ST_OK;
        case (op)
            spq_pkg::OP_INSERT: begin
                if (queue_len >= spq_pkg::DEPTH) begin
                    res.status = spq_pkg::ST_FULL;
                end else begin
                    pos = queue_len;
                    for (int i = 0; i < queue_len; i++) begin
                        if (key > queue_keys[i]) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = queue_len; i > pos; i--) begin
                        queue_keys[i] = queue_keys[i-1];
                        queue_tags[i] = queue_tags[i-1];
                    end
                    queue_keys[pos] = key;
                    queue_tags[pos] = tag;
                    queue_len++;
                end
            end
            spq_pkg::OP_REMOVE: begin
                pos = tag_position(tag);
                if (pos >= spq_pkg::DEPTH) begin
                    res.status = spq_pkg::ST_NOT_FOUND;
                end else begin
                    res.key = queue_keys[pos];
                    res.tag = queue_tags[pos];
                    for (int i = pos; i + 1 < queue_len; i++) begin
                        queue_keys[i] = queue_keys[i+1];
                        queue_tags[i] = queue_tags[i+1];
                    end
                    queue_len--;
                end
            end
            spq_pkg::OP_FIND: begin
                pos = tag_position(tag);
                if (pos >= spq_pkg::DEPTH) begin
                    res.status = spq_pkg::ST_NOT_FOUND;
                end else begin
                    res.key = queue_keys[pos];
                    res.tag = queue_tags[pos];
                end
            end
            default: begin
                if (queue_len == 0) begin
                    res.status = spq_pkg::ST_EMPTY;
                end else begin
                    res.key = queue_keys[0];
                    res.tag = queue_tags[0];
                end
            end
        endcase
        res.count = spq_pkg::CNT_W'(queue_len);
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_spq_result got;
        t_spq_result want;
        if (!i_rst_n) begin
            queue_len = 0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tuser;
                got.key    = i_m_tdata[15:0];
                got.tag    = i_m_tdata[31:16];
                got.count  = i_m_tdata[36:32];
                if (expected_results.size() == 0) begin
                    $error("result transaction with no operation outstanding: %h", got);
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    chk_cnt++;
                    check_field("status", want.status, got.status);
                    check_field("result_key", want.key, got.key);
                    check_field("result_tag", want.tag, got.tag);
                    check_field("entry_count", want.count, got.count);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(queue_operation(i_s_tuser, i_s_tdata[15:0],
                                                           i_s_tdata[31:16]));
            end
        end
        o_errors  <= err_cnt;
        o_pending <= expected_results.size();
        o_checked <= chk_cnt;
    end

endmodule

[sim/testbench.sv]
// Top of the sorted priority queue testbench: clock, reset, operation stimulus
// with random idling and back-pressure, and the final verdict.
// Depends on spq_pkg, sorted_priority_queue_top and spq_checker.
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int errors;
    int pending;
    int checked;
    int cycles = 0;
    int sent_ops [4] = '{0, 0, 0, 0};
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    always #6 i_clk = ~i_clk;

    sorted_priority_queue_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    spq_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    task automatic send_op(input logic [1:0] op, input logic [15:0] key,
                           input logic [15:0] tag);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tag, key};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_ops[op]++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_tag();
        if ($urandom_range(0, 4) != 0) begin
            return 16'($urandom_range(0, 15));
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 1) != 0) begin
            return 16'($urandom_range(0, 7));
        end
        return 16'($urandom);
    endfunction

    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int         ins_weight;
        logic [1:0] op;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_op(spq_pkg::OP_HEAD, 16'h0000, 16'h0000);
        send_op(spq_pkg::OP_REMOVE, 16'hFFFF, 16'h0001);
        send_op(spq_pkg::OP_FIND, 16'h0000, 16'h0001);
        send_op(spq_pkg::OP_INSERT, 16'hFFFF, 16'h0000);
        send_op(spq_pkg::OP_INSERT, 16'h0000, 16'hFFFF);
        send_op(spq_pkg::OP_INSERT, 16'h8000, 16'h0005);
        send_op(spq_pkg::OP_INSERT, 16'h8000, 16'h0006);
        send_op(spq_pkg::OP_INSERT, 16'h1234, 16'h0005);
        for (int i = 0; i < 11; i++) begin
            send_op(spq_pkg::OP_INSERT, 16'(i * 16'h0100), 16'(16'h0100 + i));
        end
        send_op(spq_pkg::OP_INSERT, 16'h7777, 16'h0777);
        send_op(spq_pkg::OP_FIND, 16'h0000, 16'h0006);
        send_op(spq_pkg::OP_HEAD, 16'h0000, 16'h0000);
        send_op(spq_pkg::OP_REMOVE, 16'h0000, 16'h0005);
        send_op(spq_pkg::OP_REMOVE, 16'h0000, 16'hFFFF);
        send_op(spq_pkg::OP_REMOVE, 16'h0000, 16'h0000);
        send_op(spq_pkg::OP_FIND, 16'h0000, 16'h0005);
        wait_drained();

        for (int phase = 0; phase < 20; phase++) begin
            case (phase % 4)
                0:       ins_weight = 70;
                1:       ins_weight = 15;
                2:       ins_weight = 40;
                default: ins_weight = 55;
            endcase
            if (phase == 16) begin
                idle_on = 1'b0;
            end
            for (int n = 0; n < 100; n++) begin
                if (phase == 4 && n == 10) begin
                    hold_req = 1'b1;
                end
                if ($urandom_range(0, 99) < ins_weight) begin
                    op = spq_pkg::OP_INSERT;
                end else if ($urandom_range(0, 1) != 0) begin
                    op = spq_pkg::OP_REMOVE;
                end else if ($urandom_range(0, 1) != 0) begin
                    op = spq_pkg::OP_FIND;
                end else begin
                    op = spq_pkg::OP_HEAD;
                end
                send_op(op, pick_key(), pick_tag());
            end
            if (phase % 5 == 2) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d inserts, %0d removes, %0d finds and %0d head reads",
                 sent_ops[spq_pkg::OP_INSERT], sent_ops[spq_pkg::OP_REMOVE],
                 sent_ops[spq_pkg::OP_FIND], sent_ops[spq_pkg::OP_HEAD]);
        $display("through full, empty and stalled states; %0d results compared.", checked);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
sim/spq_checker.sv
sim/testbench.sv
